@@ hw/rtl/roso_pkg.sv @@
`default_nettype none

package roso_pkg;

    localparam logic [31:0] MAG_MASK    = 32'h7FFF_FFFF;
    localparam logic [31:0] EXP_INF     = 32'h7F80_0000;
    localparam logic [31:0] SMALL_LIMIT = 32'h3D00_0000;
    localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
    localparam logic [31:0] D_POS_SAT   = 32'h7FFF_FFFF;
    localparam logic [31:0] D_NEG_SAT   = 32'h8000_0000;

    // biased exponent where 256*n reaches 2^31
    localparam logic [7:0] EXP_SAT      = 8'd150;
    // biased exponent where 256*n has unit weight at the mantissa lsb
    localparam logic [7:0] EXP_UNIT     = 8'd142;
    // smallest biased exponent for which n * 2^-16 stays normal
    localparam logic [7:0] EXP_FINE_MIN = 8'd17;
    localparam logic [7:0] EXP_FINE_SUB = 8'd16;

    localparam int AXES = 3;

    typedef struct packed {
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic [31:0] normal_z;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] above_x;
        logic [31:0] above_y;
        logic [31:0] above_z;
        logic [31:0] below_x;
        logic [31:0] below_y;
        logic [31:0] below_z;
    } out_beat_t;

    // per-axis decoded operands after the first stage
    typedef struct packed {
        logic [31:0] point;
        logic [31:0] fine;       // normal * 2^-16 as single bits
        logic [31:0] offset;     // trunc(256 * normal), saturated
        logic        near_zero;  // |point| < 1/32
        logic        neg;        // point negative, not NaN
    } prep_t;

    // per-axis integer-path results and mode
    typedef struct packed {
        logic [31:0] int_above;
        logic [31:0] int_below;
        logic        near_zero;
    } lane_t;

endpackage

`default_nettype wire

@@ hw/rtl/ray_origin_self_intersection_offset.sv @@
// Throughput: one beat per cycle unless the output stalls; a decode stage
// and the three-stage float adder set the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload
// registers are not reset.
`default_nettype none

module ray_origin_self_intersection_offset
    import roso_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_beat_t      out_data
);

    logic [3:0]  vld_reg, vld_next;
    logic        en;
    logic [31:0] pt [AXES];
    logic [31:0] nm [AXES];
    prep_t       prep_next [AXES];
    prep_t       s1_reg [AXES];
    lane_t       s2_next [AXES];
    lane_t       s2_reg [AXES];
    lane_t       s3_reg [AXES];
    lane_t       s4_reg [AXES];
    logic [31:0] f_above [AXES];
    logic [31:0] f_below [AXES];
    logic [31:0] res_above [AXES];
    logic [31:0] res_below [AXES];

    assign en       = !vld_reg[3] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[2:0], in_valid};

    assign pt[0] = in_data.point_x;
    assign pt[1] = in_data.point_y;
    assign pt[2] = in_data.point_z;
    assign nm[0] = in_data.normal_x;
    assign nm[1] = in_data.normal_y;
    assign nm[2] = in_data.normal_z;

    for (genvar k = 0; k < AXES; k++)
    begin : g_axis
        roso_prep u_prep
        (
            .point  (pt[k]),
            .normal (nm[k]),
            .prep   (prep_next[k])
        );

        // integer step on the raw pattern, direction from the point's sign
        always_comb
        begin
            s2_next[k].near_zero = s1_reg[k].near_zero;
            if (s1_reg[k].neg)
            begin
                s2_next[k].int_above = s1_reg[k].point - s1_reg[k].offset;
                s2_next[k].int_below = s1_reg[k].point + s1_reg[k].offset;
            end
            else
            begin
                s2_next[k].int_above = s1_reg[k].point + s1_reg[k].offset;
                s2_next[k].int_below = s1_reg[k].point - s1_reg[k].offset;
            end
        end

        roso_fadd u_fadd_above
        (
            .clk (clk),
            .en  (en),
            .a   (s1_reg[k].point),
            .b   (s1_reg[k].fine),
            .sum (f_above[k])
        );

        roso_fadd u_fadd_below
        (
            .clk (clk),
            .en  (en),
            .a   (s1_reg[k].point),
            .b   ({~s1_reg[k].fine[31], s1_reg[k].fine[30:0]}),
            .sum (f_below[k])
        );

        // hold payload through the stages
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_reg[k] <= prep_next[k];
                s2_reg[k] <= s2_next[k];
                s3_reg[k] <= s2_reg[k];
                s4_reg[k] <= s3_reg[k];
            end
        end

        assign res_above[k] = s4_reg[k].near_zero ? f_above[k] : s4_reg[k].int_above;
        assign res_below[k] = s4_reg[k].near_zero ? f_below[k] : s4_reg[k].int_below;
    end

    // advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid        = vld_reg[3];
    assign out_data.above_x = res_above[0];
    assign out_data.above_y = res_above[1];
    assign out_data.above_z = res_above[2];
    assign out_data.below_x = res_below[0];
    assign out_data.below_y = res_below[1];
    assign out_data.below_z = res_below[2];

    // a stalled output freezes every stage
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    // an accepted beat lands in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted beat lost at first stage");

    // the near-zero above result on x gives only the canonical NaN
    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && s4_reg[0].near_zero && ((f_above[0] & MAG_MASK) > EXP_INF)
        |-> f_above[0] == CANON_NAN)
        else $error("non-canonical NaN on x");

endmodule

`default_nettype wire

@@ hw/rtl/roso_prep.sv @@
`default_nettype none

module roso_prep
    import roso_pkg::*;
(
    input  wire logic [31:0] point,
    input  wire logic [31:0] normal,
    output prep_t            prep
);

    logic [7:0]  n_exp;
    logic [7:0]  n_expx;
    logic [23:0] n_mant;
    logic        n_nan;
    logic [31:0] mag;
    logic [31:0] offset_mag;
    logic [7:0]  rsh;
    logic [7:0]  fsh;
    logic [47:0] fwide;
    logic [23:0] fq;
    logic        fup;
    logic [23:0] fval;

    always_comb
    begin
        n_exp  = normal[30:23];
        n_expx = (n_exp == 8'd0) ? 8'd1 : n_exp;
        n_mant = {n_exp != 8'd0, normal[22:0]};
        n_nan  = (normal & MAG_MASK) > EXP_INF;

        // scale by 256 and truncate toward zero
        rsh = EXP_UNIT - n_expx;
        if (n_expx >= EXP_UNIT)
        begin
            offset_mag = {8'd0, n_mant} << (n_expx - EXP_UNIT);
        end
        else if (rsh >= 8'd24)
        begin
            offset_mag = '0;
        end
        else
        begin
            offset_mag = {8'd0, n_mant >> rsh[4:0]};
        end

        if (n_nan)
        begin
            prep.offset = '0;
        end
        else if (n_exp >= EXP_SAT)
        begin
            prep.offset = normal[31] ? D_NEG_SAT : D_POS_SAT;
        end
        else
        begin
            prep.offset = normal[31] ? (32'd0 - offset_mag) : offset_mag;
        end

        // scale by 2^-16, rounding to nearest even into the subnormal range
        fsh   = EXP_FINE_MIN - n_expx;
        fwide = {n_mant, 24'd0} >> fsh[4:0];
        fq    = fwide[47:24];
        fup   = fwide[23] & ((|fwide[22:0]) | fq[0]);
        fval  = fq + {23'd0, fup};
        if (n_exp == 8'hFF)
        begin
            prep.fine = normal;
        end
        else if (n_exp >= EXP_FINE_MIN)
        begin
            prep.fine = {normal[31], n_exp - EXP_FINE_SUB, normal[22:0]};
        end
        else
        begin
            prep.fine = {normal[31], 7'd0, fval};
        end

        mag            = point & MAG_MASK;
        prep.point     = point;
        prep.near_zero = mag < SMALL_LIMIT;
        prep.neg       = point[31] && (mag != 32'd0) && (mag <= EXP_INF);
    end

endmodule

`default_nettype wire

@@ hw/rtl/roso_fadd.sv @@
`default_nettype none

module roso_fadd
    import roso_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] sum
);

    typedef struct packed {
        logic        sign;
        logic        zsign;
        logic        sub;
        logic [7:0]  exp;
        logic [26:0] mb;
        logic [26:0] ms;
        logic        spec;
        logic [31:0] spec_bits;
    } align_t;

    typedef struct packed {
        logic        sign;
        logic        zsign;
        logic [7:0]  exp;
        logic [27:0] raw;
        logic        spec;
        logic [31:0] spec_bits;
    } add_t;

    align_t al_next, al_reg;
    add_t   ad_next, ad_reg;
    logic [31:0] sum_next, sum_reg;

    logic [31:0] amag, bmag, big, sml;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [7:0]  ebx, esx, diff;
    logic [4:0]  dcl;
    logic [26:0] ext;
    logic [53:0] wide;

    // align: order by magnitude, shift the smaller operand with sticky
    always_comb
    begin
        amag  = {1'b0, a[30:0]};
        bmag  = {1'b0, b[30:0]};
        a_nan = amag > EXP_INF;
        b_nan = bmag > EXP_INF;
        a_inf = amag == EXP_INF;
        b_inf = bmag == EXP_INF;
        big   = (amag < bmag) ? b : a;
        sml   = (amag < bmag) ? a : b;
        ebx   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        esx   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        diff  = ebx - esx;
        dcl   = (diff > 8'd27) ? 5'd27 : diff[4:0];
        ext   = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        wide  = {ext, 27'd0} >> dcl;

        al_next.sign  = big[31];
        al_next.zsign = a[31] & b[31];
        al_next.sub   = a[31] ^ b[31];
        al_next.exp   = ebx;
        al_next.mb    = {big[30:23] != 8'd0, big[22:0], 3'b000};
        al_next.ms    = {wide[53:28], wide[27] | (|wide[26:0])};
        al_next.spec  = a_nan | b_nan | a_inf | b_inf;
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
        begin
            al_next.spec_bits = CANON_NAN;
        end
        else
        begin
            al_next.spec_bits = a_inf ? a : b;
        end
    end

    // add or subtract the aligned mantissas
    always_comb
    begin
        ad_next.sign      = al_reg.sign;
        ad_next.zsign     = al_reg.zsign;
        ad_next.exp       = al_reg.exp;
        ad_next.spec      = al_reg.spec;
        ad_next.spec_bits = al_reg.spec_bits;
        if (al_reg.sub)
        begin
            ad_next.raw = {1'b0, al_reg.mb} - {1'b0, al_reg.ms};
        end
        else
        begin
            ad_next.raw = {1'b0, al_reg.mb} + {1'b0, al_reg.ms};
        end
    end

    logic [4:0]  lz;
    logic [7:0]  lim;
    logic [4:0]  sh;
    logic [26:0] norm;
    logic [8:0]  e9, efin;
    logic        rup;
    logic [24:0] mr;
    logic [23:0] mant;

    // normalize, round to nearest even, pack
    always_comb
    begin
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (ad_reg.raw[i])
            begin
                lz = 5'(26 - i);
            end
        end
        lim = ad_reg.exp - 8'd1;
        sh  = ({3'd0, lz} > lim) ? lim[4:0] : lz;
        if (ad_reg.raw[27])
        begin
            norm = {ad_reg.raw[27:2], ad_reg.raw[1] | ad_reg.raw[0]};
            e9   = {1'b0, ad_reg.exp} + 9'd1;
        end
        else
        begin
            norm = ad_reg.raw[26:0] << sh;
            e9   = {1'b0, ad_reg.exp} - {4'd0, sh};
        end
        rup  = norm[2] & (norm[1] | norm[0] | norm[3]);
        mr   = {1'b0, norm[26:3]} + {24'd0, rup};
        mant = mr[24] ? mr[24:1] : mr[23:0];
        efin = mr[24] ? e9 + 9'd1 : e9;

        if (ad_reg.spec)
        begin
            sum_next = ad_reg.spec_bits;
        end
        else if (ad_reg.raw == 28'd0)
        begin
            sum_next = {ad_reg.zsign, 31'd0};
        end
        else if (efin >= 9'd255)
        begin
            sum_next = {ad_reg.sign, EXP_INF[30:0]};
        end
        else
        begin
            sum_next = {ad_reg.sign, mant[23] ? efin[7:0] : 8'd0, mant[22:0]};
        end
    end

    // advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            al_reg  <= al_next;
            ad_reg  <= ad_next;
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire
